// File: hw/rtl/binary_morphology_window_filter_assert.svh
// Assertion macros for the binary morphology window filter checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef BINARY_MORPHOLOGY_WINDOW_FILTER_ASSERT_SVH
`define BINARY_MORPHOLOGY_WINDOW_FILTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BMWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BMWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after a reset cycle
`define BMWF_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bmwf_pkg.sv
// Shared constants, codes and types of the binary morphology window filter.
// No dependencies; used by bmwf_eval, the filter top and the checker.
package bmwf_pkg;

  localparam int KERNEL_SIZE   = 5;
  localparam int RAD           = (KERNEL_SIZE - 1) / 2;
  localparam int WIN_BITS      = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINE_BITS     = KERNEL_SIZE - 1;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int SIZE_CAP      = 1024;

  localparam int PIX_W        = 8;
  localparam int OP_W         = 2;
  localparam int SIZE_W       = 11;
  localparam int COORD_W      = 10;
  localparam int ROW_CNT_W    = 11;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = WIN_BITS;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_FIELDS_W = PIX_W + 2 * COORD_W;

  localparam logic [OP_W-1:0] OP_DILATE   = 2'd0;
  localparam logic [OP_W-1:0] OP_ERODE    = 2'd1;
  localparam logic [OP_W-1:0] OP_HIT_MISS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OPERATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  localparam logic [OP_W-1:0]     OPERATION_RST = OP_DILATE;
  localparam logic [PIX_W-1:0]    THRESHOLD_RST = 8'd128;
  localparam logic [WIN_BITS-1:0] FORE_MASK_RST = 25'd15728622;
  localparam logic [WIN_BITS-1:0] MISS_MASK_RST = 25'd4288;
  localparam logic [SIZE_W-1:0]   FRAME_W_RST   = 11'd512;
  localparam logic [SIZE_W-1:0]   FRAME_H_RST   = 11'd512;

  localparam logic [PIX_W-1:0] VAL_FG = 8'd255;
  localparam logic [PIX_W-1:0] VAL_BG = 8'd0;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [WIN_BITS-1:0] fore;
    logic [WIN_BITS-1:0] miss;
    logic [SIZE_W-1:0]   eff_w;
    logic [SIZE_W-1:0]   eff_h;
  } eval_cfg_t;

endpackage

// File: hw/rtl/bmwf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bmwf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bmwf_eval.sv
// Window evaluation: dilation, erosion and hit-and-miss over one 5x5 window.
// Depends on bmwf_pkg.
module bmwf_eval (
  input  bmwf_pkg::eval_cfg_t                 cfg,
  input  logic [bmwf_pkg::WIN_BITS-1:0]       win,
  input  logic [bmwf_pkg::COORD_W-1:0]        row,
  input  logic [bmwf_pkg::COORD_W-1:0]        col,
  output logic                                fg
);

  localparam int K  = bmwf_pkg::KERNEL_SIZE;
  localparam int NB = bmwf_pkg::WIN_BITS;
  localparam int SW = bmwf_pkg::COORD_W + 2;

  logic [NB-1:0] img;
  logic [K-1:0]  rok;
  logic [K-1:0]  cok;
  logic [NB-1:0] dil_hit;
  logic [SW-1:0] h_last;
  logic [SW-1:0] w_last;
  logic [SW-1:0] rsum [K];
  logic [SW-1:0] csum [K];
  logic          center;

  assign h_last = SW'(cfg.eff_h) - SW'(1);
  assign w_last = SW'(cfg.eff_w) - SW'(1);

  always_comb begin
    for (int p = 0; p < K; p++) begin
      rsum[p] = SW'(row) + SW'(p);
      csum[p] = SW'(col) + SW'(p);
      rok[p]  = (rsum[p] >= SW'(2 * bmwf_pkg::RAD)) && (rsum[p] <= h_last);
      cok[p]  = (csum[p] >= SW'(2 * bmwf_pkg::RAD)) && (csum[p] <= w_last);
    end
  end

  always_comb begin
    for (int p = 0; p < K; p++) begin
      for (int q = 0; q < K; q++) begin
        img[p * K + q]     = win[q * K + p];
        dil_hit[p * K + q] = cfg.fore[NB - 1 - (p * K + q)] & img[p * K + q] & rok[p] & cok[q];
      end
    end
  end

  assign center = rok[bmwf_pkg::RAD] && cok[bmwf_pkg::RAD];

  always_comb begin
    unique case (cfg.op)
      bmwf_pkg::OP_DILATE:   fg = |dil_hit;
      bmwf_pkg::OP_ERODE:    fg = center && ((img & cfg.fore) == cfg.fore);
      bmwf_pkg::OP_HIT_MISS: fg = center && ((img & cfg.fore) == cfg.fore)
                                  && ((~img & cfg.miss) == cfg.miss);
      default:               fg = 1'b0;
    endcase
  end

endmodule

// File: hw/rtl/binary_morphology_window_filter.sv
// Binary morphology filter (dilate, erode, hit-and-miss) over a 5x5 window.
// Depends on bmwf_pkg, bmwf_ram and bmwf_eval.
//
// Input stream: in_tdata carries the gray pixel, in_tuser the mode (0 pixel,
// 1 drain tick). Pixels arrive in raster order; after the last pixel of the
// frame, drain ticks (or further pixels, whose values are dropped) flush the
// remaining results. A drain tick during the frame is taken and discarded.
// Output stream: one 0/255 result per item once the window is primed; the
// result stream lags the input by two rows plus two pixels, and out_tlast
// marks the bottom-right pixel, after which a new frame starts at 0,0.
// Writing frame_width or frame_height restarts the frame.
// Throughput: one item per clock while the receiver does not stall. The line
// store is read when an item is taken and written back when that item leaves
// the window stage, so its one read and one write port set that rate. A result
// passes through the window stage and the output register to out_tvalid.
// Reset: registers return to their defaults and the position counters clear;
// the line store is not swept, since rows outside the frame never reach a
// result. When the receiver stalls, the output register holds its result,
// the item behind it waits in the window stage, and in_tready drops.
module binary_morphology_window_filter #(
  parameter int MAX_WIDTH = bmwf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bmwf_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] pixel
  input  logic                                in_tuser,   // [0] mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bmwf_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [7:0] value, [17:8] out_row,
                                                          // [27:18] out_col, [31:28] zero
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [bmwf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WCAP = (MAX_WIDTH < bmwf_pkg::SIZE_CAP) ? MAX_WIDTH : bmwf_pkg::SIZE_CAP;
  localparam int K    = bmwf_pkg::KERNEL_SIZE;
  localparam int NB   = bmwf_pkg::WIN_BITS;
  localparam int SZ   = bmwf_pkg::SIZE_W;
  localparam int CW   = bmwf_pkg::COORD_W;
  localparam int RW   = bmwf_pkg::ROW_CNT_W;
  localparam int PW   = bmwf_pkg::PIX_W;
  localparam int LB   = bmwf_pkg::LINE_BITS;

  // configuration registers
  logic [bmwf_pkg::OP_W-1:0] operation_r;
  logic [PW-1:0]             threshold_r;
  logic [NB-1:0]             fore_mask_r;
  logic [NB-1:0]             miss_mask_r;
  logic [SZ-1:0]             frame_width_r;
  logic [SZ-1:0]             frame_height_r;
  logic [SZ-1:0]             eff_w;
  logic [SZ-1:0]             eff_h;
  logic                      cfg_restart;

  // position state
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] emit_row_r, emit_row_nxt;
  logic [CW-1:0] emit_col_r, emit_col_nxt;
  logic          frame_done_r, frame_done_nxt;

  // intake
  logic          accept;
  logic          drop;
  logic          take;
  logic          bit0;
  logic [AW-1:0] addr0;
  logic          ready0;
  logic          last0;
  logic [SZ-1:0] col_inc;
  logic          col_wrap;
  logic [RW-1:0] row_inc;
  logic [SZ-1:0] emit_col_inc;

  // window stage
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_bit_r;
  logic          s1_res_r;
  logic          s1_last_r;
  logic [AW-1:0] s1_addr_r;
  logic [CW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_advance;
  logic [LB-1:0] line_rdata;
  logic [K-1:0]  col_vec;
  logic [NB-1:0] window_r, window_nxt;
  logic          fg;
  bmwf_pkg::eval_cfg_t eval_cfg;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [PW-1:0]        out_value_r;
  logic [CW-1:0]        out_row_r;
  logic [CW-1:0]        out_col_r;
  logic                 out_last_r;

  always_comb begin
    if (frame_width_r < SZ'(K)) begin
      eff_w = SZ'(K);
    end else if (frame_width_r > SZ'(WCAP)) begin
      eff_w = SZ'(WCAP);
    end else begin
      eff_w = frame_width_r;
    end
    if (frame_height_r < SZ'(K)) begin
      eff_h = SZ'(K);
    end else if (frame_height_r > SZ'(bmwf_pkg::SIZE_CAP)) begin
      eff_h = SZ'(bmwf_pkg::SIZE_CAP);
    end else begin
      eff_h = frame_height_r;
    end
  end

  assign cfg_restart = cfg_we && (cfg_index == bmwf_pkg::REG_FRAME_WIDTH ||
                                  cfg_index == bmwf_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r    <= bmwf_pkg::OPERATION_RST;
      threshold_r    <= bmwf_pkg::THRESHOLD_RST;
      fore_mask_r    <= bmwf_pkg::FORE_MASK_RST;
      miss_mask_r    <= bmwf_pkg::MISS_MASK_RST;
      frame_width_r  <= bmwf_pkg::FRAME_W_RST;
      frame_height_r <= bmwf_pkg::FRAME_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmwf_pkg::REG_OPERATION:    operation_r    <= cfg_data[bmwf_pkg::OP_W-1:0];
        bmwf_pkg::REG_THRESHOLD:    threshold_r    <= cfg_data[PW-1:0];
        bmwf_pkg::REG_FORE_MASK:    fore_mask_r    <= cfg_data[NB-1:0];
        bmwf_pkg::REG_MISS_MASK:    miss_mask_r    <= cfg_data[NB-1:0];
        bmwf_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[SZ-1:0];
        bmwf_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[SZ-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;
  assign drop   = !frame_done_r && in_tuser;
  assign take   = accept && !drop;
  assign bit0   = !frame_done_r && (in_tdata[PW-1:0] >= threshold_r);
  assign addr0  = (SZ'(in_col_r) >= eff_w) ? '0 : AW'(in_col_r);
  assign ready0 = (in_row_r > RW'(bmwf_pkg::RAD)) ||
                  (in_row_r == RW'(bmwf_pkg::RAD) && in_col_r >= CW'(bmwf_pkg::RAD));
  assign last0  = (SZ'(emit_row_r) == eff_h - SZ'(1)) && (SZ'(emit_col_r) == eff_w - SZ'(1));

  assign col_inc      = SZ'(in_col_r) + SZ'(1);
  assign col_wrap     = col_inc >= eff_w;
  assign row_inc      = in_row_r + RW'(1);
  assign emit_col_inc = SZ'(emit_col_r) + SZ'(1);

  always_comb begin
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    emit_row_nxt   = emit_row_r;
    emit_col_nxt   = emit_col_r;
    frame_done_nxt = frame_done_r;
    if (cfg_restart) begin
      in_col_nxt     = '0;
      in_row_nxt     = '0;
      emit_row_nxt   = '0;
      emit_col_nxt   = '0;
      frame_done_nxt = 1'b0;
    end else if (take) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = row_inc;
        if (SZ'(row_inc) >= eff_h) begin
          frame_done_nxt = 1'b1;
        end
      end else begin
        in_col_nxt = col_inc[CW-1:0];
      end
      if (ready0) begin
        if (last0) begin
          in_col_nxt     = '0;
          in_row_nxt     = '0;
          emit_row_nxt   = '0;
          emit_col_nxt   = '0;
          frame_done_nxt = 1'b0;
        end else if (emit_col_inc >= eff_w) begin
          emit_col_nxt = '0;
          emit_row_nxt = emit_row_r + CW'(1);
        end else begin
          emit_col_nxt = emit_col_inc[CW-1:0];
        end
      end
    end
  end

  assign s1_advance   = s1_valid_r && (!s1_res_r || !out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || s1_advance;
  assign s1_valid_nxt = take || (s1_valid_r && !s1_advance);

  // newest column enters at the top of the window; line store keeps the rows above
  assign col_vec    = {s1_bit_r, line_rdata};
  assign window_nxt = {col_vec, window_r[NB-1:K]};

  bmwf_ram #(
    .WIDTH(LB),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (s1_advance),
    .waddr(s1_addr_r),
    .wdata(col_vec[K-1:1]),
    .re   (take),
    .raddr(addr0),
    .rdata(line_rdata)
  );

  assign eval_cfg = '{op:    operation_r,
                      fore:  fore_mask_r,
                      miss:  miss_mask_r,
                      eff_w: eff_w,
                      eff_h: eff_h};

  bmwf_eval u_eval (
    .cfg(eval_cfg),
    .win(window_nxt),
    .row(s1_row_r),
    .col(s1_col_r),
    .fg (fg)
  );

  assign out_load      = s1_advance && s1_res_r;
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r     <= '0;
      in_row_r     <= '0;
      emit_row_r   <= '0;
      emit_col_r   <= '0;
      frame_done_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      window_r     <= '0;
    end else begin
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      emit_row_r   <= emit_row_nxt;
      emit_col_r   <= emit_col_nxt;
      frame_done_r <= frame_done_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (s1_advance) begin
        window_r <= window_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_bit_r  <= bit0;
      s1_res_r  <= ready0;
      s1_last_r <= last0;
      s1_addr_r <= addr0;
      s1_row_r  <= emit_row_r;
      s1_col_r  <= emit_col_r;
    end
    if (out_load) begin
      out_value_r <= fg ? bmwf_pkg::VAL_FG : bmwf_pkg::VAL_BG;
      out_row_r   <= s1_row_r;
      out_col_r   <= s1_col_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(bmwf_pkg::OUT_TDATA_W - bmwf_pkg::OUT_FIELDS_W){1'b0}},
                       out_col_r, out_row_r, out_value_r};

endmodule

// File: hw/rtl/bmwf_checker.sv
// Port-level checker for the binary morphology window filter, bound to the top.
// Depends on bmwf_pkg and binary_morphology_window_filter_assert.svh.
`include "binary_morphology_window_filter_assert.svh"

module bmwf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bmwf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast,
  input logic                              cfg_we,
  input logic [bmwf_pkg::CFG_IDX_W-1:0]    cfg_index
);

  localparam int CW = bmwf_pkg::COORD_W;
  localparam int PW = bmwf_pkg::PIX_W;

  logic          out_fire;
  logic          restart;
  logic [CW-1:0] row;
  logic [CW-1:0] col;
  logic          prev_seen_r;
  logic          prev_last_r;
  logic [CW-1:0] prev_row_r;
  logic [CW-1:0] prev_col_r;
  logic          in_order;

  assign out_fire = out_tvalid && out_tready;
  assign restart  = cfg_we && (cfg_index == bmwf_pkg::REG_FRAME_WIDTH ||
                               cfg_index == bmwf_pkg::REG_FRAME_HEIGHT);
  assign row      = out_tdata[PW + CW - 1:PW];
  assign col      = out_tdata[PW + 2 * CW - 1:PW + CW];

  // track the previous result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seen_r <= 1'b0;
    end else if (restart) begin
      prev_seen_r <= 1'b0;
    end else if (out_fire) begin
      prev_seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_last_r <= out_tlast;
      prev_row_r  <= row;
      prev_col_r  <= col;
    end
  end

  assign in_order = prev_last_r ? (row == '0 && col == '0)
                  : ((row == prev_row_r && (CW + 1)'(col) == (CW + 1)'(prev_col_r) + 1'b1) ||
                     (col == '0 && (CW + 1)'(row) == (CW + 1)'(prev_row_r) + 1'b1));

  `BMWF_ASSERT_AFTER_RESET(a_no_out_after_reset, !out_tvalid,
    "result valid right after reset")

  `BMWF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  `BMWF_ASSERT_NOW(a_raster_order, out_fire && prev_seen_r, in_order,
    "result coordinates out of raster order")

  `BMWF_ASSERT_NOW(a_last_corner, out_tvalid && out_tlast,
    row >= CW'(bmwf_pkg::KERNEL_SIZE - 1) && col >= CW'(bmwf_pkg::KERNEL_SIZE - 1),
    "frame end flagged inside the minimum frame")

endmodule

bind binary_morphology_window_filter bmwf_checker u_bmwf_checker (.*);
